[sv/fpci_pkg.sv]
// shared types, constants and saturating helpers for the four-point cubic interpolator
package fpci_pkg;

  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int NUM_IN = 9;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DIV0  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ADD_C  = 2'd0,
    ADD_MC = 2'd1,
    ADD_VN = 2'd2
  } add_sel_t;

  // everything an item carries down the pipeline
  typedef struct packed {
    status_t                   status;
    logic                      chord_f;
    logic                      chord_c;
    logic signed [ACC_W-1:0]   vn;
    logic signed [ACC_W-1:0]   dv;
    logic signed [ACC_W-1:0]   dfo;
    logic signed [ACC_W-1:0]   dno;
    logic signed [ACC_W-1:0]   g;
    logic signed [ACC_W-1:0]   p;
    logic signed [ACC_W-1:0]   a;
    logic signed [ACC_W-1:0]   b;
    logic signed [ACC_W-1:0]   s;
    logic signed [ACC_W-1:0]   e;
    logic signed [ACC_W-1:0]   mf;
    logic signed [ACC_W-1:0]   mc;
    logic signed [ACC_W-1:0]   c;
    logic signed [ACC_W-1:0]   d;
    logic signed [ACC_W-1:0]   acc;
  } ctx_t;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sx(input logic [DATA_W-1:0] v);
    sx = {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
    mag = v[ACC_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic signed [ACC_W-1:0] sadd(input logic signed [ACC_W-1:0] x,
                                                   input logic signed [ACC_W-1:0] y);
    logic signed [ACC_W:0] t;
    t = {x[ACC_W-1], x} + {y[ACC_W-1], y};
    if (t[ACC_W] != t[ACC_W-1]) sadd = t[ACC_W] ? ACC_MIN : ACC_MAX;
    else sadd = t[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] ssub(input logic signed [ACC_W-1:0] x,
                                                   input logic signed [ACC_W-1:0] y);
    logic signed [ACC_W:0] t;
    t = {x[ACC_W-1], x} - {y[ACC_W-1], y};
    if (t[ACC_W] != t[ACC_W-1]) ssub = t[ACC_W] ? ACC_MIN : ACC_MAX;
    else ssub = t[ACC_W-1:0];
  endfunction

endpackage

[sv/four_point_cubic_interpolator_unit.sv]
// top level of the four-point cubic hermite interpolator
//
// input channel s_*: one item carries four sample values, four sample positions
// and the query position, all signed q16.16. output channel m_*: the
// interpolated value in m_tdata and the status in m_tuser (ok, query outside
// the middle interval, zero divisor; the value is 0 unless the status is ok).
// fully pipelined: one item is accepted every cycle when the output is not stalled.
// the pipeline is made of five chained round(x*y/z) units (two for the slopes,
// three for the horner evaluation), each a 70-stage pipeline with a 64-step
// restoring divider, plus front, slope and output stages.
// one enable moves the whole pipeline: while a result waits with m_tready low,
// s_tready is low and every stage holds, so nothing is lost or repeated.
// reset clears all valid bits; no state survives between items.
module four_point_cubic_interpolator_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // value_outer_near, value_near, value_far, value_outer_far, pos_outer_near,
  // pos_near, pos_far, pos_outer_far, query_pos (32 bits each, lowest first)
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // interp_value
  output logic [31:0]  m_tdata,
  // status
  output logic [1:0]   m_tuser
);

  localparam int DW = fpci_pkg::DATA_W;
  localparam int AW = fpci_pkg::ACC_W;

  logic en;

  logic                 fr_valid;
  fpci_pkg::ctx_t       fr_ctx;

  logic                 l1_valid;
  logic signed [AW-1:0] l1_qf, l1_qc;
  fpci_pkg::ctx_t       l1_ctx, l1_ctx_mod;

  logic                 l2_valid;
  logic signed [AW-1:0] l2_qf_curv, l2_qc_curv, l2_qf_lin, l2_qc_lin;
  fpci_pkg::ctx_t       l2_ctx;

  logic                 sl_valid;
  fpci_pkg::ctx_t       sl_ctx;

  logic                 h1_valid, h2_valid, h3_valid;
  fpci_pkg::ctx_t       h1_ctx, h2_ctx, h3_ctx;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  fpci_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (s_tvalid),
    .value_outer_near(s_tdata[0*DW +: DW]),
    .value_near      (s_tdata[1*DW +: DW]),
    .value_far       (s_tdata[2*DW +: DW]),
    .value_outer_far (s_tdata[3*DW +: DW]),
    .pos_outer_near  (s_tdata[4*DW +: DW]),
    .pos_near        (s_tdata[5*DW +: DW]),
    .pos_far         (s_tdata[6*DW +: DW]),
    .pos_outer_far   (s_tdata[7*DW +: DW]),
    .query_pos       (s_tdata[8*DW +: DW]),
    .out_valid       (fr_valid),
    .ctx_out         (fr_ctx)
  );

  // outer difference scaled by g over the outer spacing
  fpci_muldiv u_l1_far (
    .clk(clk), .rst(rst), .en(en), .in_valid(fr_valid),
    .x(fr_ctx.dfo), .y(fr_ctx.g), .z(fr_ctx.a), .ctx_in(fr_ctx),
    .out_valid(l1_valid), .q(l1_qf), .ctx_out(l1_ctx)
  );

  fpci_muldiv u_l1_near (
    .clk(clk), .rst(rst), .en(en), .in_valid(fr_valid),
    .x(fr_ctx.dno), .y(fr_ctx.g), .z(fr_ctx.b), .ctx_in(fr_ctx),
    .out_valid(), .q(l1_qc), .ctx_out()
  );

  always_comb begin
    l1_ctx_mod    = l1_ctx;
    l1_ctx_mod.mf = l1_qf;
    l1_ctx_mod.mc = l1_qc;
  end

  fpci_muldiv u_l2_far_curv (
    .clk(clk), .rst(rst), .en(en), .in_valid(l1_valid),
    .x(l1_ctx_mod.mf), .y(l1_ctx_mod.g), .z(l1_ctx_mod.s), .ctx_in(l1_ctx_mod),
    .out_valid(l2_valid), .q(l2_qf_curv), .ctx_out(l2_ctx)
  );

  fpci_muldiv u_l2_near_curv (
    .clk(clk), .rst(rst), .en(en), .in_valid(l1_valid),
    .x(l1_ctx_mod.mc), .y(l1_ctx_mod.g), .z(l1_ctx_mod.e), .ctx_in(l1_ctx_mod),
    .out_valid(), .q(l2_qc_curv), .ctx_out()
  );

  fpci_muldiv u_l2_far_lin (
    .clk(clk), .rst(rst), .en(en), .in_valid(l1_valid),
    .x(l1_ctx_mod.dv), .y(l1_ctx_mod.a), .z(l1_ctx_mod.s), .ctx_in(l1_ctx_mod),
    .out_valid(), .q(l2_qf_lin), .ctx_out()
  );

  fpci_muldiv u_l2_near_lin (
    .clk(clk), .rst(rst), .en(en), .in_valid(l1_valid),
    .x(l1_ctx_mod.dv), .y(l1_ctx_mod.b), .z(l1_ctx_mod.e), .ctx_in(l1_ctx_mod),
    .out_valid(), .q(l2_qc_lin), .ctx_out()
  );

  fpci_slope u_slope (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (l2_valid),
    .ctx_in   (l2_ctx),
    .qf_curv  (l2_qf_curv),
    .qf_lin   (l2_qf_lin),
    .qc_curv  (l2_qc_curv),
    .qc_lin   (l2_qc_lin),
    .out_valid(sl_valid),
    .ctx_out  (sl_ctx)
  );

  fpci_horner u_h1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(sl_valid), .ctx_in(sl_ctx),
    .sel(fpci_pkg::ADD_C), .out_valid(h1_valid), .ctx_out(h1_ctx)
  );

  fpci_horner u_h2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(h1_valid), .ctx_in(h1_ctx),
    .sel(fpci_pkg::ADD_MC), .out_valid(h2_valid), .ctx_out(h2_ctx)
  );

  fpci_horner u_h3 (
    .clk(clk), .rst(rst), .en(en), .in_valid(h2_valid), .ctx_in(h2_ctx),
    .sel(fpci_pkg::ADD_VN), .out_valid(h3_valid), .ctx_out(h3_ctx)
  );

  localparam logic signed [AW-1:0] OUT_MAX = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] OUT_MIN = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= h3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= h3_ctx.status;
      if (h3_ctx.status != fpci_pkg::ST_OK) m_tdata <= '0;
      else if (h3_ctx.acc > OUT_MAX) m_tdata <= OUT_MAX[DW-1:0];
      else if (h3_ctx.acc < OUT_MIN) m_tdata <= OUT_MIN[DW-1:0];
      else m_tdata <= h3_ctx.acc[DW-1:0];
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != fpci_pkg::ST_OK) |-> (m_tdata == '0))
    else $error("error status with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == fpci_pkg::ST_OK || m_tuser == fpci_pkg::ST_RANGE
                  || m_tuser == fpci_pkg::ST_DIV0))
    else $error("undefined status code");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

[sv/fpci_muldiv.sv]
// pipelined round(x*y/z) with ties away from zero, saturated to 64 bits, 70 stages
module fpci_muldiv (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [fpci_pkg::ACC_W-1:0] x,
  input  logic signed [fpci_pkg::ACC_W-1:0] y,
  input  logic signed [fpci_pkg::ACC_W-1:0] z,
  input  fpci_pkg::ctx_t                   ctx_in,
  output logic                             out_valid,
  output logic signed [fpci_pkg::ACC_W-1:0] q,
  output fpci_pkg::ctx_t                   ctx_out
);

  localparam int W  = fpci_pkg::ACC_W;
  localparam int HW = W / 2;

  // operand magnitudes
  logic             a_valid;
  logic [W-1:0]     a_ux, a_uy, a_uz;
  logic             a_neg, a_zero;
  fpci_pkg::ctx_t   a_ctx;

  // partial products
  logic             b_valid;
  logic [W-1:0]     b_pp00, b_pp01, b_pp10, b_pp11, b_uz;
  logic             b_neg, b_zero;
  fpci_pkg::ctx_t   b_ctx;

  // full product
  logic             c_valid;
  logic [2*W-1:0]   c_prod;
  logic [W-1:0]     c_uz;
  logic             c_neg, c_zero;
  fpci_pkg::ctx_t   c_ctx;

  // divider stages: remainder and dividend bits shifting out / quotient shifting in
  logic             dval  [0:W];
  logic [W-1:0]     dr    [0:W];
  logic [W-1:0]     dl    [0:W];
  logic [W-1:0]     duz   [0:W];
  logic             dneg  [0:W];
  logic             dzero [0:W];
  logic             dover [0:W];
  fpci_pkg::ctx_t   dctx  [0:W];

  // rounding
  logic             e_valid;
  logic [W-1:0]     e_q;
  logic             e_neg, e_zero, e_over;
  fpci_pkg::ctx_t   e_ctx;

  logic [W-1:0]     rem_last, uz_last, q_last;
  logic             half;
  logic [W:0]       q_round;
  logic [W-1:0]     lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      dval[0] <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      dval[0] <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ux   <= fpci_pkg::mag(x);
      a_uy   <= fpci_pkg::mag(y);
      a_uz   <= fpci_pkg::mag(z);
      a_neg  <= (x[W-1] ^ y[W-1]) ^ z[W-1];
      a_zero <= (z == '0);
      a_ctx  <= ctx_in;

      b_pp00 <= a_ux[HW-1:0] * a_uy[HW-1:0];
      b_pp01 <= a_ux[HW-1:0] * a_uy[W-1:HW];
      b_pp10 <= a_ux[W-1:HW] * a_uy[HW-1:0];
      b_pp11 <= a_ux[W-1:HW] * a_uy[W-1:HW];
      b_uz   <= a_uz;
      b_neg  <= a_neg;
      b_zero <= a_zero;
      b_ctx  <= a_ctx;

      c_prod <= {{W{1'b0}}, b_pp00}
              + {{HW{1'b0}}, b_pp01, {HW{1'b0}}}
              + {{HW{1'b0}}, b_pp10, {HW{1'b0}}}
              + {b_pp11, {W{1'b0}}};
      c_uz   <= b_uz;
      c_neg  <= b_neg;
      c_zero <= b_zero;
      c_ctx  <= b_ctx;

      // any quotient bit above the low word means overflow
      dover[0] <= (c_prod[2*W-1:W] >= c_uz);
      dr[0]    <= (c_prod[2*W-1:W] >= c_uz) ? '0 : c_prod[2*W-1:W];
      dl[0]    <= c_prod[W-1:0];
      duz[0]   <= c_uz;
      dneg[0]  <= c_neg;
      dzero[0] <= c_zero;
      dctx[0]  <= c_ctx;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W:0] r_sh;
    logic       ge;
    logic [W:0] r_sub;

    assign r_sh  = {dr[k], dl[k][W-1]};
    assign ge    = (r_sh >= {1'b0, duz[k]});
    assign r_sub = r_sh - {1'b0, duz[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dval[k+1] <= 1'b0;
      end else if (en) begin
        dval[k+1] <= dval[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr[k+1]    <= ge ? r_sub[W-1:0] : r_sh[W-1:0];
        dl[k+1]    <= {dl[k][W-2:0], ge};
        duz[k+1]   <= duz[k];
        dneg[k+1]  <= dneg[k];
        dzero[k+1] <= dzero[k];
        dover[k+1] <= dover[k];
        dctx[k+1]  <= dctx[k];
      end
    end
  end

  assign rem_last = dr[W];
  assign uz_last  = duz[W];
  assign q_last   = dl[W];
  assign half     = (rem_last >= (uz_last - rem_last));
  assign q_round  = {1'b0, q_last} + {{W{1'b0}}, half};
  assign lim      = e_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      e_valid   <= dval[W];
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_q    <= q_round[W-1:0];
      e_over <= dover[W] | q_round[W];
      e_neg  <= dneg[W];
      e_zero <= dzero[W];
      e_ctx  <= dctx[W];

      if (e_zero) q <= '0;
      else if (e_over || (e_q > lim)) q <= e_neg ? fpci_pkg::ACC_MIN : fpci_pkg::ACC_MAX;
      else q <= e_neg ? $signed(~e_q + 1'b1) : $signed(e_q);
      ctx_out <= e_ctx;
    end
  end

endmodule

[sv/fpci_front.sv]
// front stages: differences of positions and values, range and divisor checks
module fpci_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [fpci_pkg::DATA_W-1:0]       value_outer_near,
  input  logic [fpci_pkg::DATA_W-1:0]       value_near,
  input  logic [fpci_pkg::DATA_W-1:0]       value_far,
  input  logic [fpci_pkg::DATA_W-1:0]       value_outer_far,
  input  logic [fpci_pkg::DATA_W-1:0]       pos_outer_near,
  input  logic [fpci_pkg::DATA_W-1:0]       pos_near,
  input  logic [fpci_pkg::DATA_W-1:0]       pos_far,
  input  logic [fpci_pkg::DATA_W-1:0]       pos_outer_far,
  input  logic [fpci_pkg::DATA_W-1:0]       query_pos,
  output logic                              out_valid,
  output fpci_pkg::ctx_t                    ctx_out
);

  logic           v1, v2;
  fpci_pkg::ctx_t c1, c2;
  fpci_pkg::ctx_t c1_next, c2_next, ctx_next;
  logic           out_range, g_zero, a_zero, b_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_comb begin
    c1_next         = '0;
    c1_next.status  = fpci_pkg::ST_OK;
    c1_next.chord_f = (value_outer_far == value_far);
    c1_next.chord_c = (value_outer_near == value_near);
    c1_next.vn      = fpci_pkg::sx(value_near);
    c1_next.dv      = fpci_pkg::sx(value_far) - fpci_pkg::sx(value_near);
    c1_next.dfo     = fpci_pkg::sx(value_outer_far) - fpci_pkg::sx(value_far);
    c1_next.dno     = fpci_pkg::sx(value_outer_near) - fpci_pkg::sx(value_near);
    c1_next.g       = fpci_pkg::sx(pos_far) - fpci_pkg::sx(pos_near);
    c1_next.p       = fpci_pkg::sx(query_pos) - fpci_pkg::sx(pos_near);
    c1_next.a       = fpci_pkg::sx(pos_outer_far) - fpci_pkg::sx(pos_far);
    c1_next.b       = fpci_pkg::sx(pos_outer_near) - fpci_pkg::sx(pos_near);
  end

  always_comb begin
    c2_next   = c1;
    c2_next.s = c1.a + c1.g;
    c2_next.e = c1.g - c1.b;
  end

  always_comb begin
    ctx_next = c2;
    // range test takes priority over divisor checks
    if (out_range) ctx_next.status = fpci_pkg::ST_RANGE;
    else if (g_zero
             || (!c2.chord_f && (a_zero || c2.s == '0))
             || (!c2.chord_c && (b_zero || c2.e == '0)))
      ctx_next.status = fpci_pkg::ST_DIV0;
    else ctx_next.status = fpci_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1        <= c1_next;
      c2        <= c2_next;
      out_range <= c1.p[fpci_pkg::ACC_W-1] || (c1.p > c1.g);
      g_zero    <= (c1.g == '0);
      a_zero    <= (c1.a == '0);
      b_zero    <= (c1.b == '0);
      ctx_out   <= ctx_next;
    end
  end

endmodule

[sv/fpci_slope.sv]
// slope combine and cubic coefficient stages
module fpci_slope (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  fpci_pkg::ctx_t                    ctx_in,
  input  logic signed [fpci_pkg::ACC_W-1:0] qf_curv,
  input  logic signed [fpci_pkg::ACC_W-1:0] qf_lin,
  input  logic signed [fpci_pkg::ACC_W-1:0] qc_curv,
  input  logic signed [fpci_pkg::ACC_W-1:0] qc_lin,
  output logic                              out_valid,
  output fpci_pkg::ctx_t                    ctx_out
);

  logic           v1, v2;
  fpci_pkg::ctx_t c1, c2;
  fpci_pkg::ctx_t c1_next, c2_next, ctx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_comb begin
    c1_next    = ctx_in;
    c1_next.mf = ctx_in.chord_f ? ctx_in.dv : fpci_pkg::sadd(qf_lin, qf_curv);
    c1_next.mc = ctx_in.chord_c ? ctx_in.dv : fpci_pkg::ssub(qc_curv, qc_lin);
  end

  // c holds 3dv - mf, d holds 2mc, acc holds mf + mc for now
  always_comb begin
    c2_next     = c1;
    c2_next.c   = fpci_pkg::ssub(c1.dv + c1.dv + c1.dv, c1.mf);
    c2_next.d   = fpci_pkg::sadd(c1.mc, c1.mc);
    c2_next.acc = fpci_pkg::sadd(c1.mf, c1.mc);
  end

  always_comb begin
    ctx_next     = c2;
    ctx_next.c   = fpci_pkg::ssub(c2.c, c2.d);
    ctx_next.acc = fpci_pkg::ssub(c2.acc, c2.dv + c2.dv);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1      <= c1_next;
      c2      <= c2_next;
      ctx_out <= ctx_next;
    end
  end

endmodule

[sv/fpci_horner.sv]
// one horner step: acc * p / g plus the next coefficient
module fpci_horner (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  fpci_pkg::ctx_t       ctx_in,
  input  fpci_pkg::add_sel_t   sel,
  output logic                 out_valid,
  output fpci_pkg::ctx_t       ctx_out
);

  logic                              md_valid;
  logic signed [fpci_pkg::ACC_W-1:0] md_q;
  fpci_pkg::ctx_t                    md_ctx;
  logic signed [fpci_pkg::ACC_W-1:0] addend;
  fpci_pkg::ctx_t                    ctx_next;

  fpci_muldiv u_md (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .x        (ctx_in.acc),
    .y        (ctx_in.p),
    .z        (ctx_in.g),
    .ctx_in   (ctx_in),
    .out_valid(md_valid),
    .q        (md_q),
    .ctx_out  (md_ctx)
  );

  always_comb begin
    case (sel)
      fpci_pkg::ADD_C:  addend = md_ctx.c;
      fpci_pkg::ADD_MC: addend = md_ctx.mc;
      fpci_pkg::ADD_VN: addend = md_ctx.vn;
      default:          addend = '0;
    endcase
  end

  always_comb begin
    ctx_next     = md_ctx;
    ctx_next.acc = fpci_pkg::sadd(md_q, addend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= md_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_out <= ctx_next;
    end
  end

endmodule

[sim/fpci_checker.sv]
// checker for the four-point cubic interpolator: predicts each result and compares it
module fpci_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [287:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [31:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  output int           fail_count,
  output int           pending,
  output int           result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0]       value;
    fpci_pkg::status_t stat;
  } interp_t;

  interp_t expected_q[$];
  int      ok_seen, range_seen, div0_seen;

  localparam logic signed [63:0] I64_MAX = 64'sh7fffffffffffffff;
  localparam logic signed [63:0] I64_MIN = 64'sh8000000000000000;

  function automatic logic signed [63:0] add_sat(logic signed [63:0] x, logic signed [63:0] y);
    logic signed [64:0] t;
    t = 65'(x) + 65'(y);
    if (t > 65'(I64_MAX)) return I64_MAX;
    if (t < 65'(I64_MIN)) return I64_MIN;
    return t[63:0];
  endfunction

  function automatic logic signed [63:0] sub_sat(logic signed [63:0] x, logic signed [63:0] y);
    logic signed [64:0] t;
    t = 65'(x) - 65'(y);
    if (t > 65'(I64_MAX)) return I64_MAX;
    if (t < 65'(I64_MIN)) return I64_MIN;
    return t[63:0];
  endfunction

  // round(x*y/z), ties away from zero, saturated to 64 bits
  function automatic logic signed [63:0] scale_round(logic signed [63:0] x,
                                                     logic signed [63:0] y,
                                                     logic signed [63:0] z);
    logic signed [129:0] prod, q, r, az;
    logic                neg;
    if (z == 0) return 0;
    prod = 130'(x) * 130'(y);
    neg  = (prod < 0) != (z < 0);
    if (prod < 0) prod = -prod;
    az = (z < 0) ? -130'(z) : 130'(z);
    q  = prod / az;
    r  = prod % az;
    if (2 * r >= az) q = q + 1;
    if (neg) q = -q;
    if (q > 130'(I64_MAX)) return I64_MAX;
    if (q < 130'(I64_MIN)) return I64_MIN;
    return q[63:0];
  endfunction

  function automatic interp_t interpolate(logic [287:0] item);
    logic signed [63:0] von, vn, vf, vof, pon, pn, pf, pof, qp;
    logic signed [63:0] g, p, dv, mf, mc, a, s, b, e, c, d, acc;
    interp_t res;
    von = 64'(signed'(item[31:0]));    vn  = 64'(signed'(item[63:32]));
    vf  = 64'(signed'(item[95:64]));   vof = 64'(signed'(item[127:96]));
    pon = 64'(signed'(item[159:128])); pn  = 64'(signed'(item[191:160]));
    pf  = 64'(signed'(item[223:192])); pof = 64'(signed'(item[255:224]));
    qp  = 64'(signed'(item[287:256]));
    res.value = '0;
    res.stat  = fpci_pkg::ST_OK;
    g = sub_sat(pf, pn);
    p = sub_sat(qp, pn);
    mf = 0;
    mc = 0;
    if (p < 0 || p > g) begin
      res.stat = fpci_pkg::ST_RANGE;
      return res;
    end
    if (g == 0) begin
      res.stat = fpci_pkg::ST_DIV0;
      return res;
    end
    dv = sub_sat(vf, vn);
    if (vof == vf) mf = dv;
    else begin
      a = sub_sat(pof, pf);
      s = add_sat(a, g);
      if (a == 0 || s == 0) begin
        res.stat = fpci_pkg::ST_DIV0;
        return res;
      end
      mf = add_sat(scale_round(dv, a, s),
                   scale_round(scale_round(sub_sat(vof, vf), g, a), g, s));
    end
    if (von == vn) mc = dv;
    else begin
      b = sub_sat(pon, pn);
      e = sub_sat(g, b);
      if (b == 0 || e == 0) begin
        res.stat = fpci_pkg::ST_DIV0;
        return res;
      end
      mc = sub_sat(scale_round(scale_round(sub_sat(von, vn), g, b), g, e),
                   scale_round(dv, b, e));
    end
    c = sub_sat(sub_sat(add_sat(add_sat(dv, dv), dv), mf), add_sat(mc, mc));
    d = sub_sat(add_sat(mf, mc), add_sat(dv, dv));
    acc = add_sat(scale_round(d, p, g), c);
    acc = add_sat(scale_round(acc, p, g), mc);
    acc = add_sat(scale_round(acc, p, g), vn);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    res.value = acc[31:0];
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    interp_t want;
    if (rst) begin
      expected_q.delete();
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(interpolate(s_tdata));
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        case (m_tuser)
          fpci_pkg::ST_OK:    ok_seen++;
          fpci_pkg::ST_RANGE: range_seen++;
          default:            div0_seen++;
        endcase
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result value=%h status=%0d", m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (m_tdata !== want.value || m_tuser !== want.stat) begin
            if (fail_count < 10)
              $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                       want.value, want.stat, m_tdata, m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[sim/testbench.sv]
// stimulus and verdict for the four-point cubic interpolator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready;
  logic [287:0] s_tdata;
  logic [31:0]  m_tdata;
  logic [1:0]   m_tuser;
  int           fail_count, pending, result_count;
  int           cycles;
  logic         hold_off;

  four_point_cubic_interpolator_unit DUT (.*);
  fpci_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(0, 200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  // ordered positions with a query inside the middle interval, mostly well formed
  function automatic logic [287:0] make_item(int kind);
    logic [31:0] v[4], pos[4], q;
    int          step;
    foreach (v[i]) v[i] = rnd_word();
    step = (kind == 0) ? $urandom_range(1, 1 << 20) : $urandom_range(1, 1 << 28);
    pos[1] = 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
    pos[0] = pos[1] - 32'($urandom_range(1, step));
    pos[2] = pos[1] + 32'($urandom_range(1, step));
    pos[3] = pos[2] + 32'($urandom_range(1, step));
    q = pos[1] + 32'($urandom_range(0, pos[2] - pos[1]));
    if ($urandom_range(0, 9) == 0) v[0] = v[1];
    if ($urandom_range(0, 9) == 0) v[3] = v[2];
    if ($urandom_range(0, 9) == 0) v[$urandom_range(0, 3)] = rnd_word();
    if (kind == 2) begin
      foreach (pos[i]) pos[i] = rnd_word();
      q = rnd_word();
    end else if (kind == 3) begin
      // zero divisors: coincident outer point or mirrored one
      case ($urandom_range(0, 3))
        0: pos[3] = pos[2];
        1: pos[0] = pos[1];
        2: pos[3] = pos[1];
        default: pos[0] = pos[2];
      endcase
    end
    return {q, pos[3], pos[2], pos[1], pos[0], v[3], v[2], v[1], v[0]};
  endfunction

  task automatic send(logic [287:0] item);
    int gap;
    gap = gap_len();
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else if ($urandom_range(0, 99) < 8) m_tready <= 1'b0;
    else if ($urandom_range(0, 99) < 3) m_tready <= 1'b0;
    else m_tready <= 1'b1;
  end

  initial begin
    hold_off = 1'b0;
    @(negedge rst);
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    repeat (700) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    rst = 1; s_tvalid = 0; s_tdata = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    // directed: extremes, chord slopes, range and divisor cases
    send({32'h8000, 32'h30000, 32'h20000, 32'h10000, 32'h0, 32'h4, 32'h3, 32'h2, 32'h1} << 0);
    send({32'h10000, 32'h20000, 32'h10000, 32'h0, mn, mx, mn, mx, mn});
    send({32'h10000, 32'h20000, 32'h10000, 32'h0, mx, mn, mx, mn, mx});
    send({32'h18000, 32'h30000, 32'h20000, 32'h10000, 32'h0, mx, mx, mn, mn});
    send({32'h18000, 32'h30000, 32'h20000, 32'h10000, 32'h0, mn, mn, mx, mx});
    send({mn, 32'h30000, 32'h20000, 32'h10000, 32'h0, 32'h0, 32'h5, 32'h5, 32'h0});
    send({mx, 32'h30000, 32'h20000, 32'h10000, 32'h0, 32'h0, 32'h5, 32'h5, 32'h0});
    send({32'h10000, 32'h30000, 32'h10000, 32'h10000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'h10000, 32'h30000, 32'h20000, 32'h10000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'h10000, 32'h30000, 32'h20000, 32'h10000, 32'h10000, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'h10000, 32'h10000, 32'h20000, 32'h10000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'h10000, 32'h30000, 32'h10000, 32'h10000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'h10000, mx, 32'h10000, 32'h0, mn, 32'h2, mn, mx, 32'h4});
    send({32'h8000, 32'h20000, 32'h10000, 32'h0, 32'h10000, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'h8000, 32'h30000, 32'h20000, 32'h10000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'h20000, 32'h30000, 32'h20000, 32'h10000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'h10000, 32'h30000, 32'h20000, 32'h10000, 32'h0, mx, mx, mx, mx});
    send({32'h10000, 32'h30000, 32'h20000, 32'h10000, 32'h0, mn, mn, mn, mn});
    send({32'h10000, 32'h30000, 32'h20000, 32'h10000, 32'h0, mn, mx, mn, mx});
    send({32'h10001, 32'h30000, 32'h20000, 32'h10000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'hffff, 32'h30000, 32'h20000, 32'h10000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4});
    send({32'h10000, 32'h10000, 32'h20000, 32'h10000, 32'h20000, 32'h1, 32'h2, 32'h3, 32'h4});
    for (int n = 0; n < 1850; n++) begin
      int r;
      r = $urandom_range(0, 99);
      send(make_item(r < 45 ? 0 : r < 80 ? 1 : r < 90 ? 2 : 3));
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d results: %0d ok, %0d outside interval, %0d zero divisor",
             result_count, checker_i.ok_seen, checker_i.range_seen, checker_i.div0_seen);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
